>>> rtl/nose_hoover_thermostat_step_defines.svh
`ifndef NOSE_HOOVER_THERMOSTAT_STEP_DEFINES_SVH
`define NOSE_HOOVER_THERMOSTAT_STEP_DEFINES_SVH

// same-cycle implication
`define NHT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nht check failed");

// next-cycle implication
`define NHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nht check failed");

`endif

>>> rtl/nht_pkg.sv
package nht_pkg;

    localparam int DATA_W    = 32;
    localparam int DOF_W     = 24;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int NUM_W     = 88;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FORM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_T0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KB   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MASS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TAU  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DT   = 3'd5;

    localparam logic [DATA_W-1:0] POS_CAP = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] NEG_CAP = 32'h8000_0000;

    localparam logic signed [65:0] WIDE_MAX = 66'sd2147483647;
    localparam logic signed [65:0] WIDE_MIN = -66'sd2147483648;

    typedef struct packed {
        logic                     mode;
        logic [DATA_W-1:0]        measured_temperature;
        logic [DOF_W-1:0]         freedom_count;
        logic signed [DATA_W-1:0] velocity_x;
        logic signed [DATA_W-1:0] velocity_y;
        logic signed [DATA_W-1:0] velocity_z;
        logic signed [DATA_W-1:0] accel_in_x;
        logic signed [DATA_W-1:0] accel_in_y;
        logic signed [DATA_W-1:0] accel_in_z;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] accel_out_x;
        logic signed [DATA_W-1:0] accel_out_y;
        logic signed [DATA_W-1:0] accel_out_z;
        logic signed [DATA_W-1:0] friction_now;
        logic                     zero_temperature;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic [DATA_W-1:0] abs32(input logic signed [DATA_W-1:0] x);
        logic [DATA_W-1:0] u;
        u = x;
        return x[DATA_W-1] ? (~u + 32'd1) : u;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > WIDE_MAX) begin
            r = POS_CAP;
        end else if (v < WIDE_MIN) begin
            r = NEG_CAP;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/nose_hoover_thermostat_step.sv
// channel  direction  handshake            payload
// in       input      i_in_valid/o_in_stall   i_in_item (t_in_item)
// out      output     o_out_valid/i_out_stall o_out_item (t_out_item)
// cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// one item at a time; atom items run S_START, S_AX_MUL/S_AX_ACC per axis, S_DONE, then S_IDLE
// mass form updates run S_M1..S_M4 and one division, relaxation form two divisions
// the 88-step restoring divider sets the update latency, one quotient bit a cycle
// reset is synchronous, active low; friction clears, registers return to 1.0, form to mass
// a waiting result is held in the output register while the next item is taken

module nose_hoover_thermostat_step #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  nht_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output nht_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nht_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nht_pkg::DATA_W-1:0]    i_cfg_data
);
    import nht_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_AX_MUL = 4'd2;
    localparam logic [3:0] S_AX_ACC = 4'd3;
    localparam logic [3:0] S_M1     = 4'd4;
    localparam logic [3:0] S_M2     = 4'd5;
    localparam logic [3:0] S_M3     = 4'd6;
    localparam logic [3:0] S_M4     = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_DT     = 4'd9;
    localparam logic [3:0] S_UPD    = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

    logic [3:0]               r_state, n_state;
    logic [1:0]               r_axis;
    logic                     r_phase;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_fric;

    logic                     r_form;
    logic [DATA_W-1:0]        r_t0, r_kb, r_mass, r_tau, r_dt;

    t_in_item                 r_item;
    t_out_item                r_out_item;
    logic [DATA_W-1:0]        r_mag;
    logic                     r_neg;
    logic [DATA_W-1:0]        r_hi;
    logic [PROD_W-1:0]        r_lop;
    logic [DATA_W-1:0]        r_rate;
    logic signed [DATA_W-1:0] r_ax, r_ay, r_az;
    logic                     r_flag;

    logic                     accept;
    logic                     out_free;
    logic                     t_zero;
    logic [DATA_W-1:0]        mul_a, mul_b;
    logic [PROD_W-1:0]        mul_prod;
    logic                     div_start;
    logic [NUM_W-1:0]         div_num;
    logic [DATA_W-1:0]        div_den;
    t_div_stat                div_stat;
    logic [NUM_W-1:0]         div_quot;
    logic                     div_again;

    logic signed [DATA_W-1:0] vel_sel, acc_sel, acc_res;
    logic [PROD_W-1:0]        shifted;
    logic signed [65:0]       shifted_w;
    logic signed [65:0]       acc_wide, fric_wide;
    logic [DATA_W-1:0]        cap32;
    logic [DATA_W-1:0]        rate_sat;

    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign t_zero      = (r_item.measured_temperature == '0);
    assign div_again   = div_stat.done && r_form && !r_phase;

    nht_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    nht_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    always_comb begin
        case (r_axis)
            AX_X: begin
                vel_sel = r_item.velocity_x;
                acc_sel = r_item.accel_in_x;
            end
            AX_Y: begin
                vel_sel = r_item.velocity_y;
                acc_sel = r_item.accel_in_y;
            end
            default: begin
                vel_sel = r_item.velocity_z;
                acc_sel = r_item.accel_in_z;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            S_AX_MUL: begin
                mul_a = abs32(r_fric);
                mul_b = abs32(vel_sel);
            end
            S_M1: begin
                mul_a = r_kb;
                mul_b = r_mag;
            end
            S_M2: begin
                mul_a = mul_prod[DATA_W-1:0];
                mul_b = DATA_W'(r_item.freedom_count);
            end
            S_M3: begin
                mul_a = r_hi;
                mul_b = DATA_W'(r_item.freedom_count);
            end
            S_DT: begin
                mul_a = r_rate;
                mul_b = r_dt;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (r_state)
            S_START: begin
                if (!r_item.mode && !t_zero && r_form) begin
                    div_start = 1'b1;
                    div_num   = NUM_W'(r_mag) << FRAC_BITS;
                    div_den   = r_item.measured_temperature;
                end
            end
            S_M4: begin
                div_start = 1'b1;
                div_num   = NUM_W'(r_lop) + (NUM_W'(mul_prod) << DATA_W);
                div_den   = r_mass;
            end
            S_DIV: begin
                if (div_again) begin
                    div_start = 1'b1;
                    div_num   = div_quot << FRAC_BITS;
                    div_den   = r_tau;
                end
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // shared datapath after the multiplier
    assign shifted   = mul_prod >> FRAC_BITS;
    assign shifted_w = $signed({2'b00, shifted});
    assign acc_wide  = (r_fric[DATA_W-1] ^ vel_sel[DATA_W-1]) ?
                       66'(acc_sel) + shifted_w : 66'(acc_sel) - shifted_w;
    assign acc_res   = sat32(acc_wide);
    assign fric_wide = r_neg ? 66'(r_fric) - shifted_w : 66'(r_fric) + shifted_w;

    assign cap32    = r_neg ? NEG_CAP : POS_CAP;
    assign rate_sat = ((|div_quot[NUM_W-1:DATA_W]) || (div_quot[DATA_W-1:0] > cap32)) ?
                      cap32 : div_quot[DATA_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (r_item.mode) begin
                    n_state = S_AX_MUL;
                end else if (t_zero) begin
                    n_state = S_DONE;
                end else if (r_form) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_M1;
                end
            end
            S_AX_MUL: n_state = S_AX_ACC;
            S_AX_ACC: n_state = (r_axis == AX_Z) ? S_DONE : S_AX_MUL;
            S_M1:     n_state = S_M2;
            S_M2:     n_state = S_M3;
            S_M3:     n_state = S_M4;
            S_M4:     n_state = S_DIV;
            S_DIV: begin
                if (div_stat.done && !div_again) begin
                    n_state = S_DT;
                end
            end
            S_DT:     n_state = S_UPD;
            S_UPD:    n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= AX_X;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
            r_fric      <= '0;
            r_form      <= 1'b0;
            r_t0        <= ONE;
            r_kb        <= ONE;
            r_mass      <= ONE;
            r_tau       <= ONE;
            r_dt        <= ONE;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FORM: r_form <= i_cfg_data[0];
                    CFG_T0:   r_t0   <= i_cfg_data;
                    CFG_KB:   r_kb   <= i_cfg_data;
                    CFG_MASS: r_mass <= i_cfg_data;
                    CFG_TAU:  r_tau  <= i_cfg_data;
                    CFG_DT:   r_dt   <= i_cfg_data;
                    default:  r_form <= r_form;
                endcase
            end
            if (r_state == S_START) begin
                r_axis  <= AX_X;
                r_phase <= 1'b0;
            end
            if (r_state == S_AX_ACC) begin
                r_axis <= r_axis + 2'd1;
            end
            if (r_state == S_DIV && div_again) begin
                r_phase <= 1'b1;
            end
            if (r_state == S_UPD) begin
                r_fric <= sat32(fric_wide);
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_item;
            r_neg  <= i_in_item.measured_temperature < r_t0;
            r_mag  <= (i_in_item.measured_temperature < r_t0) ?
                      r_t0 - i_in_item.measured_temperature :
                      i_in_item.measured_temperature - r_t0;
        end
        if (r_state == S_START) begin
            r_ax   <= '0;
            r_ay   <= '0;
            r_az   <= '0;
            r_flag <= !r_item.mode && t_zero;
        end
        if (r_state == S_M2) begin
            r_hi <= mul_prod[PROD_W-1:DATA_W];
        end
        if (r_state == S_M3) begin
            r_lop <= mul_prod;
        end
        if (r_state == S_AX_ACC) begin
            case (r_axis)
                AX_X:    r_ax <= acc_res;
                AX_Y:    r_ay <= acc_res;
                default: r_az <= acc_res;
            endcase
        end
        if (r_state == S_DIV && div_stat.done) begin
            r_rate <= rate_sat;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_item.accel_out_x      <= r_ax;
            r_out_item.accel_out_y      <= r_ay;
            r_out_item.accel_out_z      <= r_az;
            r_out_item.friction_now     <= r_fric;
            r_out_item.zero_temperature <= r_flag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> rtl/nht_mul.sv
module nht_mul (
    input  logic                        i_clk,
    input  logic [nht_pkg::DATA_W-1:0]  i_a,
    input  logic [nht_pkg::DATA_W-1:0]  i_b,
    output logic [nht_pkg::PROD_W-1:0]  o_prod
);
    import nht_pkg::*;

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

>>> rtl/nht_div.sv
module nht_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [nht_pkg::NUM_W-1:0]   i_num,
    input  logic [nht_pkg::DATA_W-1:0]  i_den,
    output nht_pkg::t_div_stat          o_stat,
    output logic [nht_pkg::NUM_W-1:0]   o_quot
);
    import nht_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0]  r_num;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DATA_W:0]   rem2;
    logic [DATA_W:0]   diff;
    logic              ge;

    assign rem2 = {r_rem, r_num[NUM_W-1]};
    assign diff = rem2 - {1'b0, r_den};
    assign ge   = rem2 >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring division, quotient bits shift in behind the numerator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= (i_den == '0) ? DATA_W'(1) : i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], ge};
            r_rem <= ge ? diff[DATA_W-1:0] : rem2[DATA_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_num;

endmodule

>>> rtl/nht_checker.sv
`include "nose_hoover_thermostat_step_defines.svh"

module nht_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input nht_pkg::t_out_item o_out_item
);
    import nht_pkg::*;

    logic out_held;
    logic flagged;
    logic accel_zero;

    assign out_held   = o_out_valid && i_out_stall;
    assign flagged    = o_out_valid && o_out_item.zero_temperature;
    assign accel_zero = (o_out_item.accel_out_x == '0) && (o_out_item.accel_out_y == '0) &&
                        (o_out_item.accel_out_z == '0);

    `NHT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    `NHT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(o_out_item))

    `NHT_ASSERT_NOW(a_flag_no_accel, i_clk, i_rst_n, flagged, accel_zero)

    `NHT_ASSERT_NOW(a_result_after_work, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule

bind nose_hoover_thermostat_step nht_checker u_nht_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import nht_pkg::*;

    localparam int     FRAC_BITS       = 16;
    localparam int     PHASES          = 8;
    localparam int     ITEMS_PER_PHASE = 54;
    localparam int     HOLD_CYCLES     = 300;
    localparam int     TAIL_CYCLES     = 250;
    localparam longint WATCHDOG_NS     = 20_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    class friction_tracker;
        bit               form;
        bit [31:0]        t_target;
        bit [31:0]        k_boltz;
        bit [31:0]        mass;
        bit [31:0]        tau;
        bit [31:0]        dt;
        bit signed [31:0] friction;
        t_out_item        pending_results[$];
        int               mismatches;

        function new();
            form       = 1'b0;
            t_target   = 32'd1 << FRAC_BITS;
            k_boltz    = 32'd1 << FRAC_BITS;
            mass       = 32'd1 << FRAC_BITS;
            tau        = 32'd1 << FRAC_BITS;
            dt         = 32'd1 << FRAC_BITS;
            friction   = '0;
            mismatches = 0;
        endfunction

        function void write_register(bit [CFG_IDX_W-1:0] idx, bit [31:0] data);
            case (idx)
                CFG_FORM: form = data[0];
                CFG_T0:   t_target = data;
                CFG_KB:   k_boltz = data;
                CFG_MASS: mass = data;
                CFG_TAU:  tau = data;
                CFG_DT:   dt = data;
                default: ;
            endcase
        endfunction

        // floor(num*mult/div) clamped, zero divisor taken as one lsb
        function bit [63:0] scaled_quotient(bit [63:0] num, bit [63:0] mult, bit [63:0] div,
                                            bit [63:0] cap);
            bit [63:0] q;
            bit [63:0] r;
            bit [63:0] v;
            if (div == 0) div = 1;
            if (mult == 0) return 0;
            q = num / div;
            r = num % div;
            if (q > cap) return cap;
            v = q * mult + (r * mult) / div;
            return (v > cap) ? cap : v;
        endfunction

        function bit signed [31:0] clamp_word(longint v);
            if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'h8000_0000;
            return v[31:0];
        endfunction

        function void take_item(t_in_item it);
            t_out_item             res;
            bit [63:0]             temp;
            bit [63:0]             dof;
            bit [63:0]             mag;
            bit [63:0]             cap;
            bit [63:0]             rate;
            bit [63:0]             ratio;
            bit [63:0]             stepm;
            bit [63:0]             pmag;
            bit                    below;
            longint                acc;
            longint                vel;
            longint                acl;
            longint                prod;
            logic signed [31:0]    vel_axis [3];
            logic signed [31:0]    acl_axis [3];
            logic signed [31:0]    out_axis [3];
            res = '0;
            if (it.mode == 1'b0) begin
                temp = 64'(it.measured_temperature);
                dof  = 64'(it.freedom_count);
                if (temp == 0) begin
                    res.zero_temperature = 1'b1;
                end else begin
                    below = temp < 64'(t_target);
                    mag   = below ? 64'(t_target) - temp : temp - 64'(t_target);
                    cap   = below ? 64'h8000_0000 : 64'h7FFF_FFFF;
                    if (!form) begin
                        rate = scaled_quotient(64'(k_boltz) * mag, dof, 64'(mass), cap);
                    end else begin
                        ratio = (mag << FRAC_BITS) / temp;
                        rate  = scaled_quotient(ratio, 64'd1 << FRAC_BITS, 64'(tau), cap);
                    end
                    stepm = (rate * 64'(dt)) >> FRAC_BITS;
                    acc   = longint'(friction);
                    if (below) begin
                        acc = acc - longint'(stepm);
                    end else begin
                        acc = acc + longint'(stepm);
                    end
                    friction = clamp_word(acc);
                end
            end else begin
                vel_axis[0] = it.velocity_x;
                vel_axis[1] = it.velocity_y;
                vel_axis[2] = it.velocity_z;
                acl_axis[0] = it.accel_in_x;
                acl_axis[1] = it.accel_in_y;
                acl_axis[2] = it.accel_in_z;
                acc = longint'(friction);
                for (int k = 0; k < 3; k++) begin
                    vel  = longint'(vel_axis[k]);
                    acl  = longint'(acl_axis[k]);
                    prod = acc * vel;
                    pmag = (prod < 0) ? -prod : prod;
                    pmag = pmag >> FRAC_BITS;
                    if (prod < 0) begin
                        out_axis[k] = clamp_word(acl + longint'(pmag));
                    end else begin
                        out_axis[k] = clamp_word(acl - longint'(pmag));
                    end
                end
                res.accel_out_x = out_axis[0];
                res.accel_out_y = out_axis[1];
                res.accel_out_z = out_axis[2];
            end
            res.friction_now = friction;
            pending_results.push_back(res);
        endfunction

        function void compare_field(string name, bit [31:0] want, bit [31:0] got);
            if (want !== got) begin
                $display("%0t %s expected %h actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void match_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected item expected none actual %h", $time, got);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("accel_out_x", want.accel_out_x, got.accel_out_x);
            compare_field("accel_out_y", want.accel_out_y, got.accel_out_y);
            compare_field("accel_out_z", want.accel_out_z, got.accel_out_z);
            compare_field("friction_now", want.friction_now, got.friction_now);
            compare_field("zero_temperature", 32'(want.zero_temperature),
                          32'(got.zero_temperature));
        endfunction
    endclass

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_item   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_item;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DATA_W-1:0]    i_cfg_data  = '0;

    int hold_requests = 0;

    friction_tracker sb = new();

    nose_hoover_thermostat_step #(.FRAC_BITS(FRAC_BITS)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.match_result(o_out_item);
            if (i_in_valid && !o_in_stall) sb.take_item(i_in_item);
            if (i_cfg_valid && o_cfg_ready) sb.write_register(i_cfg_index, i_cfg_data);
        end
    end

    function automatic int small_signed(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic bit [31:0] pick_word(bit [31:0] typical);
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return '1;
            2:       return 32'd1;
            3, 4:    return $urandom;
            default: return typical;
        endcase
    endfunction

    function automatic t_in_item update_item(bit [31:0] temp, bit [23:0] dof);
        t_in_item it;
        it.mode                 = 1'b0;
        it.measured_temperature = temp;
        it.freedom_count        = dof;
        it.velocity_x           = $urandom;
        it.velocity_y           = $urandom;
        it.velocity_z           = $urandom;
        it.accel_in_x           = $urandom;
        it.accel_in_y           = $urandom;
        it.accel_in_z           = $urandom;
        return it;
    endfunction

    function automatic t_in_item atom_item(bit [31:0] vx, bit [31:0] vy, bit [31:0] vz,
                                           bit [31:0] ax, bit [31:0] ay, bit [31:0] az);
        t_in_item it;
        it.mode                 = 1'b1;
        it.measured_temperature = $urandom;
        it.freedom_count        = 24'($urandom);
        it.velocity_x           = vx;
        it.velocity_y           = vy;
        it.velocity_z           = vz;
        it.accel_in_x           = ax;
        it.accel_in_y           = ay;
        it.accel_in_z           = az;
        return it;
    endfunction

    function automatic bit [31:0] pick_velocity();
        case ($urandom_range(0, 9))
            0:             return 32'h7FFF_FFFF;
            1:             return 32'h8000_0000;
            2, 3, 4, 5:    return small_signed(4 << FRAC_BITS);
            default:       return $urandom;
        endcase
    endfunction

    function automatic bit [31:0] pick_accel();
        return ($urandom_range(0, 9) < 3) ? small_signed(16 << FRAC_BITS) : $urandom;
    endfunction

    function automatic bit [31:0] pick_temperature();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return sb.t_target;
            2:       return sb.t_target + small_signed(8 << FRAC_BITS);
            3:       return '1;
            4:       return 32'd1;
            5, 6:    return $urandom_range(1, 600) << FRAC_BITS;
            default: return $urandom;
        endcase
    endfunction

    function automatic bit [23:0] pick_dof();
        case ($urandom_range(0, 9))
            0:             return 24'd0;
            1:             return 24'hFF_FFFF;
            2, 3, 4, 5, 6: return 24'($urandom_range(1, 3000));
            default:       return 24'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_item();
        if ($urandom_range(0, 99) < 78)
            return atom_item(pick_velocity(), pick_velocity(), pick_velocity(),
                             pick_accel(), pick_accel(), pick_accel());
        return update_item(pick_temperature(), pick_dof());
    endfunction

    task automatic offer_item(input t_in_item it);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic idle_cycles(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic program_registers(input bit form, input bit [31:0] t0, input bit [31:0] kb,
                                     input bit [31:0] mass, input bit [31:0] tau,
                                     input bit [31:0] dt);
        write_reg(CFG_FORM, ($urandom & 32'hFFFF_FFFE) | 32'(form));
        write_reg(CFG_T0, t0);
        write_reg(CFG_KB, kb);
        write_reg(CFG_MASS, mass);
        write_reg(CFG_TAU, tau);
        write_reg(CFG_DT, dt);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : receiver
        stall_style_t style;
        int           seg;
        int           holds_done;
        int           tick;
        holds_done = 0;
        tick       = 0;
        @(posedge i_clk);
        forever begin
            style = stall_style_t'($urandom_range(0, 3));
            seg   = $urandom_range(16, 120);
            repeat (seg) begin
                if (holds_done != hold_requests) begin
                    holds_done++;
                    i_out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                tick++;
                case (style)
                    STALL_NONE:     i_out_stall <= 1'b0;
                    STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:    i_out_stall <= ($urandom_range(0, 3) != 0);
                    STALL_PERIODIC: i_out_stall <= (tick % 3 != 0);
                    default:        i_out_stall <= 1'b0;
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int burst_left;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // mass form at reset settings
        offer_item(atom_item(32'h7FFF_FFFF, 32'h8000_0000, 32'd0,
                             32'h7FFF_FFFF, 32'h8000_0000, 32'd0));
        offer_item(update_item(32'd0, 24'hFF_FFFF));
        offer_item(update_item(32'd1 << FRAC_BITS, 24'd5));
        offer_item(update_item(32'd2 << FRAC_BITS, 24'd1));
        offer_item(atom_item(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                             32'h8000_0000, 32'h7FFF_FFFF, 32'd0));
        offer_item(atom_item(32'd1, 32'hFFFF_FFFF, 32'h0001_8000,
                             32'd0, 32'd0, 32'h0003_0000));
        offer_item(update_item('1, 24'hFF_FFFF));
        offer_item(atom_item(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                             32'h8000_0000, 32'h7FFF_FFFF, 32'd5));
        offer_item(update_item(32'd1, 24'hFF_FFFF));
        offer_item(update_item(32'd3 << FRAC_BITS, 24'd0));
        offer_item(atom_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom));

        // relaxation form, spare indexes must be ignored
        drain_results();
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, $urandom);
        program_registers(1'b1, 32'd1 << FRAC_BITS, 32'd1 << FRAC_BITS, 32'd1 << FRAC_BITS,
                          32'd1 << FRAC_BITS, 32'd1 << FRAC_BITS);
        offer_item(update_item(32'd0, 24'd7));
        offer_item(update_item('1, 24'd0));
        offer_item(update_item(32'd1, 24'hFF_FFFF));
        offer_item(update_item(32'd2 << FRAC_BITS, 24'd3));
        offer_item(atom_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000,
                             32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000));

        // zero divisors
        drain_results();
        program_registers(1'b0, 32'd0, '1, 32'd0, 32'd0, '1);
        offer_item(update_item(32'd5, 24'd3));
        offer_item(atom_item(32'h0001_0000, 32'hFFFF_0000, 32'd1,
                             32'd0, 32'h8000_0000, 32'h7FFF_FFFF));
        drain_results();
        program_registers(1'b1, '1, 32'd1 << FRAC_BITS, 32'd0, 32'd0, 32'd1 << FRAC_BITS);
        offer_item(update_item(32'd7, 24'd9));
        offer_item(atom_item(32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000,
                             32'd0, 32'd0, 32'h7FFF_FFFF));

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            case (p)
                0:       program_registers(1'b0, '1, '1, '1, '1, '1);
                1:       program_registers(1'b1, 32'd0, 32'd0, 32'd1, 32'd1, 32'd1);
                default: program_registers(1'($urandom_range(0, 1)),
                                           pick_word($urandom_range(1, 400) << FRAC_BITS),
                                           pick_word($urandom_range(1, 1 << 14)),
                                           pick_word($urandom_range(1, 4000) << FRAC_BITS),
                                           pick_word($urandom_range(1, 4000) << FRAC_BITS),
                                           pick_word($urandom_range(1, 1 << 10)));
            endcase
            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 3 && n == 20) hold_requests <= hold_requests + 1;
                if (p == 5 && n == 28) begin
                    drain_results();
                    burst_left = $urandom_range(1, 24);
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 10));
                end
                burst_left--;
                offer_item(random_item());
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("nose_hoover_thermostat_step: match");
        end else begin
            $display("nose_hoover_thermostat_step: mismatch");
        end
        $finish;
    end

    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("nose_hoover_thermostat_step: mismatch");
        $finish;
    end
endmodule
